/* rtl/svc_pkg.sv */
// ----------------------------------------------------------------------------
// svc_pkg
// Shared constants and codes for the stepper velocity commander.
// ----------------------------------------------------------------------------
`default_nettype none

package svc_pkg;

  // Default parameter values
  localparam int DEF_FRAC_BITS     = 8;
  localparam int DEF_POSITION_BITS = 32;

  // Fixed arithmetic constants
  localparam int          PERIOD_FRAC      = 16;
  localparam logic [29:0] NS_PER_SECOND    = 30'd1000000000;
  localparam logic [29:0] INTERVAL_OUT_MAX = 30'd1000000000;

  // Shared multiplier operand width (signed) and product width
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Register map indexes
  localparam logic [2:0] REG_ZERO_POS   = 3'd0;
  localparam logic [2:0] REG_LIMIT      = 3'd1;
  localparam logic [2:0] REG_MAX_VEL    = 3'd2;
  localparam logic [2:0] REG_PERIOD     = 3'd3;
  localparam logic [2:0] REG_MIN_IVL    = 3'd4;
  localparam logic [2:0] REG_IVL_FLOOR  = 3'd5;
  localparam logic [2:0] REG_MAX_IVL    = 3'd6;
  localparam logic [2:0] REG_TIMEOUT    = 3'd7;

  // Register reset values
  localparam logic [31:0] RST_ZERO_POS  = 32'd0;
  localparam logic [20:0] RST_LIMIT     = 21'd1200;
  localparam logic [30:0] RST_MAX_VEL   = 31'd912658;
  localparam logic [15:0] RST_PERIOD    = 16'd655;
  localparam logic [29:0] RST_MIN_IVL   = 30'd60000;
  localparam logic [29:0] RST_IVL_FLOOR = 30'd280499;
  localparam logic [31:0] RST_MAX_IVL   = 32'd1000000000;
  localparam logic [7:0]  RST_TIMEOUT   = 8'd20;

  // Result action codes
  localparam logic [1:0] ACT_STOP  = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_RANGE = 2'd2;

endpackage

`default_nettype wire

/* rtl/svc_mul.sv */
// ----------------------------------------------------------------------------
// svc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_mul
  import svc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  op_a,
  input  wire logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0]      prod_r
);

  // Product register, no reset needed
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

/* rtl/svc_div.sv */
// ----------------------------------------------------------------------------
// svc_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_div
  import svc_pkg::*;
#(
  parameter int DVD_W = 38,
  parameter int DVS_W = 31
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy_r,
  output logic                  done_r,
  output logic [DVD_W-1:0]      quot_r
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W:0]   shifted;
  logic             fits;

  // Trial subtract of the next partial remainder
  always_comb begin
    shifted = {rem_r, quot_r[DVD_W-1]};
    fits    = (shifted >= {1'b0, divisor});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
    end else if (busy_r) begin
      rem_r  <= fits ? DVS_W'(shifted - {1'b0, divisor}) : shifted[DVS_W-1:0];
      quot_r <= {quot_r[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* rtl/stepper_velocity_commander.sv */
// ----------------------------------------------------------------------------
// stepper_velocity_commander
// Per-tick velocity integrator and microstep interval/target generator.
// ----------------------------------------------------------------------------
// Usage:
//   One item per control tick enters on the in_ channel (valid/stall). The
//   block holds in_stall high while it works on that item and lowers it once
//   the result is parked in the output register.
//   Each item yields exactly one result on the out_ channel (valid/stall).
//   The result register holds its item while out_stall is high; the next
//   item is then accepted but its result waits until the register frees.
//   A zero-velocity item passes S_MUL1, S_INTEG and S_OUT; an item whose
//   interval is out of range also passes S_MULMIN, S_MULMAX and S_CHKMAX; a
//   move adds the S_DIV phase, in which the serial divider produces the
//   interval (FRAC_BITS+30 quotient bits). A new item is taken only after
//   the result of the last one is parked in the output register.
//   One signed multiplier is shared across integration, the interval range
//   checks and the target projection.
//   Write registers over the APB port only while the block is idle (not
//   enforced). A zero_position write also reloads the last known position.
//   Reset (rst_n low, synchronous) restores register defaults, clears held
//   acceleration, velocity and stale count, and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_velocity_commander
  import svc_pkg::*;
#(
  parameter int FRAC_BITS     = DEF_FRAC_BITS,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_new_command,
  input  wire logic signed [31:0] in_command_accel,
  input  wire logic               in_position_valid,
  input  wire logic signed [31:0] in_meas_pos,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_action,
  output logic [29:0]             out_step_period,
  output logic signed [31:0]      out_goal_pos,
  output logic signed [31:0]      out_velocity_out,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int NUM_W = 30 + FRAC_BITS;
  localparam int RND_S = FRAC_BITS + PERIOD_FRAC;
  localparam logic [NUM_W-1:0] NUM = {NS_PER_SECOND, {FRAC_BITS{1'b0}}};
  localparam logic signed [35:0] PMAX = (36'sd1 <<< (POSITION_BITS - 1)) - 36'sd1;
  localparam logic signed [35:0] PMIN = -PMAX - 36'sd1;

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL1   = 3'd1;
  localparam logic [2:0] S_INTEG  = 3'd2;
  localparam logic [2:0] S_MULMIN = 3'd3;
  localparam logic [2:0] S_MULMAX = 3'd4;
  localparam logic [2:0] S_CHKMAX = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // Configuration registers
  logic signed [31:0] zero_pos_r;
  logic [20:0]        limit_r;
  logic [30:0]        max_vel_r;
  logic [15:0]        period_r;
  logic [29:0]        min_ivl_r;
  logic [29:0]        ivl_floor_r;
  logic [31:0]        max_ivl_r;
  logic [7:0]         timeout_r;

  // Tick state
  logic [2:0]         state_r;
  logic signed [31:0] held_accel_r;
  logic signed [31:0] velocity_r;
  logic [7:0]         stale_r;
  logic signed [31:0] last_pos_r;
  logic [30:0]        speed_r;
  logic               lt_min_r;

  // Staged result
  logic [1:0]         res_action_r;
  logic [29:0]        res_interval_r;
  logic signed [31:0] res_target_r;

  logic               out_valid_r;
  logic [1:0]         out_action_r;
  logic [29:0]        out_interval_r;
  logic signed [31:0] out_target_r;
  logic signed [31:0] out_velocity_r;

  logic               in_accept;
  logic               cfg_write;
  logic               out_free;
  logic [2:0]         reg_idx;

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0]        mul_pu;

  // Divider
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  // Integration datapath
  logic signed [31:0] accel_step;
  logic signed [33:0] vsum;
  logic signed [33:0] maxv;
  logic signed [33:0] vclamp;
  logic signed [33:0] rel;
  logic signed [33:0] lim34;
  logic signed [33:0] vfin;
  logic signed [33:0] vabs;
  logic               gt_max;

  // Move datapath
  logic [NUM_W-1:0]   ivl_a;
  logic [NUM_W-1:0]   ivl_b;
  logic [NUM_W-1:0]   ivl_c;
  logic [PROD_W-1:0]  rnd;
  logic [PROD_W-1:0]  smag;
  logic signed [35:0] step;
  logic signed [35:0] pos36;
  logic signed [35:0] zero36;
  logic signed [35:0] lim36;
  logic signed [35:0] lo_raw;
  logic signed [35:0] hi_raw;
  logic signed [35:0] lo;
  logic signed [35:0] hi;
  logic signed [35:0] tsum;
  logic signed [35:0] tgt;

  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !out_valid_r || !out_stall;
  assign reg_idx   = paddr[4:2];
  assign in_stall  = (state_r != S_IDLE);
  assign pready    = 1'b1;

  // Multiplier operand select by phase
  always_comb begin
    mul_a = {{2{1'b0}}, speed_r};
    mul_b = {{(MUL_W-16){1'b0}}, period_r};
    case (state_r)
      S_MUL1: begin
        mul_a = {held_accel_r[31], held_accel_r};
      end
      S_MULMIN: begin
        mul_b = {{3{1'b0}}, min_ivl_r};
      end
      S_MULMAX: begin
        mul_b = {1'b0, max_ivl_r};
      end
      default: begin
      end
    endcase
  end

  svc_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  assign mul_pu = $unsigned(mul_p);

  assign div_start = (state_r == S_CHKMAX) && !lt_min_r && !gt_max;

  svc_div #(
    .DVD_W (NUM_W),
    .DVS_W (31)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (NUM),
    .divisor  (speed_r),
    .busy_r   (div_busy),
    .done_r   (div_done),
    .quot_r   (div_quot)
  );

  // Integrate, clamp and apply the travel-limit hard stop; flag an over-max interval
  always_comb begin
    accel_step = mul_p[47:16];
    vsum   = {{2{velocity_r[31]}}, velocity_r} + {{2{accel_step[31]}}, accel_step};
    maxv   = {3'b0, max_vel_r};
    vclamp = vsum;
    if (vsum > maxv) vclamp = maxv;
    if (vsum < -maxv) vclamp = -maxv;
    rel   = {{2{last_pos_r[31]}}, last_pos_r} - {{2{zero_pos_r[31]}}, zero_pos_r};
    lim34 = {13'b0, limit_r};
    vfin  = vclamp;
    if ((rel >= lim34 && vclamp > 34'sd0) || (rel <= -lim34 && vclamp < 34'sd0)) begin
      vfin = '0;
    end
    vabs   = (vfin < 34'sd0) ? -vfin : vfin;
    gt_max = (PROD_W'(NUM) > mul_pu);
  end

  // Interval clamps and projected target
  always_comb begin
    ivl_a = (div_quot < NUM_W'(ivl_floor_r)) ? NUM_W'(ivl_floor_r) : div_quot;
    ivl_b = (ivl_a > NUM_W'(max_ivl_r)) ? NUM_W'(max_ivl_r) : ivl_a;
    ivl_c = (ivl_b > NUM_W'(INTERVAL_OUT_MAX)) ? NUM_W'(INTERVAL_OUT_MAX) : ivl_b;
    rnd   = {mul_pu[PROD_W-2:0], 1'b0} + (PROD_W'(1) << (RND_S - 1));
    smag  = rnd >> RND_S;
    step  = velocity_r[31] ? -$signed(smag[35:0]) : $signed(smag[35:0]);
    pos36  = 36'(last_pos_r);
    zero36 = 36'(zero_pos_r);
    lim36  = {15'b0, limit_r};
    lo_raw = zero36 - lim36;
    hi_raw = zero36 + lim36;
    lo = (lo_raw < PMIN) ? PMIN : ((lo_raw > PMAX) ? PMAX : lo_raw);
    hi = (hi_raw < PMIN) ? PMIN : ((hi_raw > PMAX) ? PMAX : hi_raw);
    tsum = pos36 + step;
    tgt  = (tsum < lo) ? lo : ((tsum > hi) ? hi : tsum);
  end

  // Configuration registers and last known position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_pos_r  <= RST_ZERO_POS;
      limit_r     <= RST_LIMIT;
      max_vel_r   <= RST_MAX_VEL;
      period_r    <= RST_PERIOD;
      min_ivl_r   <= RST_MIN_IVL;
      ivl_floor_r <= RST_IVL_FLOOR;
      max_ivl_r   <= RST_MAX_IVL;
      timeout_r   <= RST_TIMEOUT;
      last_pos_r  <= RST_ZERO_POS;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ZERO_POS: begin
          zero_pos_r <= pwdata;
          last_pos_r <= pwdata;
        end
        REG_LIMIT:     limit_r     <= pwdata[20:0];
        REG_MAX_VEL:   max_vel_r   <= pwdata[30:0];
        REG_PERIOD:    period_r    <= pwdata[15:0];
        REG_MIN_IVL:   min_ivl_r   <= pwdata[29:0];
        REG_IVL_FLOOR: ivl_floor_r <= pwdata[29:0];
        REG_MAX_IVL:   max_ivl_r   <= pwdata;
        REG_TIMEOUT:   timeout_r   <= pwdata[7:0];
        default: begin
        end
      endcase
    end else if (in_accept && in_position_valid) begin
      last_pos_r <= 32'(signed'(in_meas_pos[POSITION_BITS-1:0]));
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_ZERO_POS:  prdata = zero_pos_r;
      REG_LIMIT:     prdata = 32'(limit_r);
      REG_MAX_VEL:   prdata = 32'(max_vel_r);
      REG_PERIOD:    prdata = 32'(period_r);
      REG_MIN_IVL:   prdata = 32'(min_ivl_r);
      REG_IVL_FLOOR: prdata = 32'(ivl_floor_r);
      REG_MAX_IVL:   prdata = max_ivl_r;
      REG_TIMEOUT:   prdata = 32'(timeout_r);
      default:       prdata = '0;
    endcase
  end

  // Sequencer and tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_accel_r <= '0;
      velocity_r   <= '0;
      stale_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (in_new_command) begin
              held_accel_r <= in_command_accel;
              stale_r      <= '0;
            end else if (stale_r < timeout_r) begin
              stale_r <= stale_r + 1'b1;
            end else begin
              held_accel_r <= '0;
              velocity_r   <= '0;
            end
            state_r <= S_MUL1;
          end
        end
        S_MUL1: state_r <= S_INTEG;
        S_INTEG: begin
          velocity_r <= vfin[31:0];
          state_r    <= (vfin == 34'sd0) ? S_OUT : S_MULMIN;
        end
        S_MULMIN: state_r <= S_MULMAX;
        S_MULMAX: state_r <= S_CHKMAX;
        S_CHKMAX: state_r <= div_start ? S_DIV : S_OUT;
        S_DIV:    state_r <= div_done ? S_OUT : S_DIV;
        S_OUT:    state_r <= out_free ? S_IDLE : S_OUT;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath captures along the sequence
  always_ff @(posedge clk) begin
    case (state_r)
      S_INTEG: begin
        speed_r        <= vabs[30:0];
        res_action_r   <= ACT_STOP;
        res_interval_r <= '0;
        res_target_r   <= '0;
      end
      S_MULMAX: begin
        lt_min_r <= (PROD_W'(NUM) < mul_pu);
      end
      S_CHKMAX: begin
        if (!div_start) res_action_r <= ACT_RANGE;
      end
      S_DIV: begin
        if (div_done) begin
          res_action_r   <= ACT_MOVE;
          res_interval_r <= ivl_c[29:0];
          res_target_r   <= tgt[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_action_r   <= res_action_r;
      out_interval_r <= res_interval_r;
      out_target_r   <= res_target_r;
      out_velocity_r <= velocity_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_step_period  = out_interval_r;
  assign out_goal_pos     = out_target_r;
  assign out_velocity_out = out_velocity_r;

  // Checks
  a_stop_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_MOVE |-> out_step_period == '0 && out_goal_pos == '0)
    else $error("stop item carries interval or target");

  a_stop_no_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_STOP |-> out_velocity_out == '0)
    else $error("stop item with nonzero velocity");

  a_div_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider running outside its phase");

  a_move_ivl_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_MOVE |-> out_step_period <= INTERVAL_OUT_MAX)
    else $error("move interval above output cap");

endmodule

`default_nettype wire
